// ===== rtl/ppa_pkg.sv =====
// Package of the physical page allocator: request and response words, page count,
// command, kind and status codes, flag bit positions and sequencer states.
// Depends on nothing; the top level and the sequencer import it.
package ppa_pkg;

	// Number of physical pages held in the flag and link memories.
	localparam int MAX_PAGES = 1024;

	// Width of the counters and of the page count register on the ports.
	localparam int CNT_W  = 11;
	localparam int PAGE_W = 10;
	localparam int FLAG_W = 3;

	// Bit positions inside one page's flag entry.
	localparam int FL_AVAIL = 0;
	localparam int FL_DMA   = 1;
	localparam int FL_KERN  = 2;

	// Command codes.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	// Allocation kinds.
	localparam logic [1:0] KIND_REG  = 2'd0;
	localparam logic [1:0] KIND_KERN = 2'd1;
	localparam logic [1:0] KIND_DMA  = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_NOFIT   = 2'd1;
	localparam logic [1:0] STAT_BADSIZE = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [PAGE_W-1:0] page_index;
		logic              page_is_free;
		logic              page_is_dma;
		logic              page_is_kernel;
		logic [CNT_W-1:0]  request_size;
		logic [1:0]        dest_kind;
	} ppa_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] grant_page;
		logic [CNT_W-1:0]  free_count;
		logic [CNT_W-1:0]  dma_free_count;
		logic [CNT_W-1:0]  kernel_count;
	} ppa_rsp_t;

	// Counter adjustments requested by the sequencer for one cycle.
	typedef struct packed {
		logic free_inc;
		logic free_dec;
		logic dma_inc;
		logic dma_dec;
		logic kern_inc;
		logic kern_dec;
	} ppa_cnt_upd_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD_RD,
		S_LOAD_WR,
		S_CSCAN,
		S_CTAKE,
		S_RSCAN,
		S_RTAKE,
		S_RLAST,
		S_FREE_RD,
		S_FREE_WR,
		S_DONE
	} ppa_state_t;

endpackage

// ===== rtl/physical_page_allocator.sv =====
// Physical page allocator. A word is taken when start is high and busy low;
// exactly one result word follows, shown for one cycle with done high, and
// the receiver cannot stall it. After reset the block is busy while it clears
// the page flag memory. A load reads and then writes one page's flags; a free
// reads each page it walks along the links and marks it available. An
// allocation scans the flag memory one page per cycle, from page 1 up to below
// min(pages_in_use, MAX_PAGES), to find a fit, then walks again up to the last
// granted page to mark the granted pages. The flag memory has a single read
// port. The page count register may only be written while the block is idle.
// Depends on ppa_pkg and ppa_seq, which uses ppa_ram.
module physical_page_allocator
	import ppa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ppa_req_t         req,
	output logic             done,
	output ppa_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int LW = $clog2(MAX_PAGES + 1);
	localparam int SW = (LW > CNT_W) ? LW : CNT_W;

	logic [CNT_W-1:0] pages_q;
	logic [SW-1:0]    free_q, dma_q, kern_q;
	logic             seq_busy, seq_done, go;
	logic [1:0]       seq_status;
	logic [PAGE_W-1:0] seq_first;
	ppa_cnt_upd_t     upd;
	logic             done_q;
	ppa_rsp_t         rsp_q;

	assign go = start && !seq_busy;

	ppa_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.req          (req),
		.pages_in_use (pages_q),
		.free_total   (free_q),
		.busy         (seq_busy),
		.done         (seq_done),
		.status       (seq_status),
		.grant_page   (seq_first),
		.upd          (upd)
	);

	// Page count register and the three page counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= CNT_W'(1024);
			free_q  <= '0;
			dma_q   <= '0;
			kern_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				pages_q <= cfg_data;
			end
			free_q <= free_q + SW'(upd.free_inc) - SW'(upd.free_dec);
			dma_q  <= dma_q + SW'(upd.dma_inc) - SW'(upd.dma_dec);
			kern_q <= kern_q + SW'(upd.kern_inc) - SW'(upd.kern_dec);
			done_q <= seq_done;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (seq_done) begin
			rsp_q.status         <= seq_status;
			rsp_q.grant_page     <= seq_first;
			rsp_q.free_count     <= free_q[CNT_W-1:0];
			rsp_q.dma_free_count <= dma_q[CNT_W-1:0];
			rsp_q.kernel_count   <= kern_q[CNT_W-1:0];
		end
	end

	assign busy = seq_busy;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/ppa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ppa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ppa_seq.sv =====
// Sequencer and scan unit of the page allocator: serves load, allocate and free
// words on the flag and link memories, scanning one page per cycle to allocate.
// Depends on ppa_pkg and ppa_ram.
module ppa_seq
	import ppa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  ppa_req_t            req,
	input  logic [CNT_W-1:0]    pages_in_use,
	input  logic [(($clog2(MAX_PAGES + 1) > CNT_W) ? $clog2(MAX_PAGES + 1) : CNT_W) - 1:0]
	                            free_total,
	output logic                busy,
	output logic                done,
	output logic [1:0]          status,
	output logic [PAGE_W-1:0]   grant_page,
	output ppa_cnt_upd_t        upd
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam int LW = $clog2(MAX_PAGES + 1);
	localparam int SW = (LW > CNT_W) ? LW : CNT_W;

	ppa_state_t state_q, state_d;

	ppa_req_t          req_q;
	logic [SW-1:0]     p_q, p_s1, end_q, run_q, prev_q, first_q;
	logic              vld_s1;
	logic [AW-1:0]     clr_q;
	logic [1:0]        status_q;

	// Memory ports.
	logic              fl_we, ln_we;
	logic [AW-1:0]     fl_waddr, fl_raddr, ln_waddr;
	logic [FLAG_W-1:0] fl_wdata, fl_rdata;
	logic [AW-1:0]     ln_wdata, ln_rdata;
	logic              issue;

	// Helper terms.
	logic [SW-1:0] limit, size_w, nxt_w;
	logic          want_dma, fits, in_range, idx_ok, link_end;

	ppa_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_PAGES)) u_flags (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.raddr (fl_raddr),
		.rdata (fl_rdata)
	);

	ppa_ram #(.WIDTH(AW), .DEPTH(MAX_PAGES)) u_links (
		.clk   (clk),
		.we    (ln_we),
		.waddr (ln_waddr),
		.wdata (ln_wdata),
		.raddr (fl_raddr),
		.rdata (ln_rdata)
	);

	// Scan limit and per-page tests.
	always_comb begin
		limit    = (SW'(pages_in_use) < SW'(MAX_PAGES)) ? SW'(pages_in_use) : SW'(MAX_PAGES);
		size_w   = SW'(req_q.request_size);
		want_dma = (req_q.dest_kind == KIND_DMA);
		fits     = fl_rdata[FL_AVAIL] && (!want_dma || fl_rdata[FL_DMA]);
		in_range = (p_s1 < limit);
		idx_ok   = (SW'(req.page_index) < SW'(MAX_PAGES));
		nxt_w    = SW'(ln_rdata);
		link_end = (ln_rdata == '0) || (nxt_w <= p_q) || (nxt_w >= SW'(MAX_PAGES));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(MAX_PAGES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (go) begin
					case (req.cmd)
						CMD_LOAD:  state_d = idx_ok ? S_LOAD_RD : S_DONE;
						CMD_FREE:  state_d = idx_ok ? S_FREE_RD : S_DONE;
						CMD_ALLOC: begin
							if (req.request_size == '0 ||
							    SW'(req.request_size) > free_total) begin
								state_d = S_DONE;
							end else if (req.dest_kind == KIND_KERN ||
							             req.dest_kind == KIND_DMA) begin
								state_d = S_CSCAN;
							end else if (req.dest_kind == KIND_REG) begin
								state_d = S_RSCAN;
							end else begin
								state_d = S_DONE;
							end
						end
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_LOAD_RD: state_d = S_LOAD_WR;
			S_LOAD_WR: state_d = S_DONE;
			S_CSCAN: begin
				if (vld_s1) begin
					if (!in_range) begin
						state_d = S_DONE;
					end else if (fits && (run_q + 1'b1 == size_w)) begin
						state_d = S_CTAKE;
					end
				end
			end
			S_CTAKE: begin
				if (vld_s1 && p_s1 == end_q) begin
					state_d = S_DONE;
				end
			end
			S_RSCAN: begin
				if (vld_s1) begin
					if (!in_range) begin
						state_d = S_DONE;
					end else if (fl_rdata[FL_AVAIL] && (run_q + 1'b1 == size_w)) begin
						state_d = S_RTAKE;
					end
				end
			end
			S_RTAKE: begin
				if (vld_s1 && p_s1 == end_q) begin
					state_d = S_RLAST;
				end
			end
			S_RLAST:   state_d = S_DONE;
			S_FREE_RD: state_d = S_FREE_WR;
			S_FREE_WR: begin
				if (fl_rdata[FL_AVAIL] || link_end) begin
					state_d = S_DONE;
				end else begin
					state_d = S_FREE_RD;
				end
			end
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory ports, counter adjustments and strobes.
	always_comb begin
		fl_we    = 1'b0;
		fl_waddr = p_s1[AW-1:0];
		fl_wdata = fl_rdata;
		fl_raddr = p_q[AW-1:0];
		ln_we    = 1'b0;
		ln_waddr = p_s1[AW-1:0];
		ln_wdata = '0;
		issue    = 1'b0;
		upd      = '0;
		done     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				fl_we    = 1'b1;
				fl_waddr = clr_q;
				fl_wdata = '0;
			end
			S_LOAD_WR: begin
				fl_we         = 1'b1;
				fl_waddr      = p_q[AW-1:0];
				fl_wdata      = {req_q.page_is_kernel, req_q.page_is_dma, req_q.page_is_free};
				upd.free_dec  = fl_rdata[FL_AVAIL];
				upd.dma_dec   = fl_rdata[FL_AVAIL] && fl_rdata[FL_DMA];
				upd.kern_dec  = fl_rdata[FL_KERN];
				upd.free_inc  = req_q.page_is_free;
				upd.dma_inc   = req_q.page_is_free && req_q.page_is_dma;
				upd.kern_inc  = req_q.page_is_kernel;
			end
			S_CSCAN, S_RSCAN: issue = 1'b1;
			S_CTAKE: begin
				issue = (p_q <= end_q);
				if (vld_s1) begin
					fl_we             = 1'b1;
					fl_wdata[FL_AVAIL] = 1'b0;
					ln_we             = 1'b1;
					ln_wdata          = (p_s1 == end_q) ? '0 : AW'(p_s1 + 1'b1);
					upd.free_dec      = 1'b1;
					upd.dma_dec       = fl_rdata[FL_DMA];
				end
			end
			S_RTAKE: begin
				issue = (p_q <= end_q);
				if (vld_s1 && fl_rdata[FL_AVAIL]) begin
					fl_we             = 1'b1;
					fl_wdata[FL_AVAIL] = 1'b0;
					ln_we             = (prev_q != '0);
					ln_waddr          = prev_q[AW-1:0];
					ln_wdata          = p_s1[AW-1:0];
					upd.free_dec      = 1'b1;
					upd.dma_dec       = fl_rdata[FL_DMA];
				end
			end
			S_RLAST: begin
				ln_we    = 1'b1;
				ln_waddr = end_q[AW-1:0];
				ln_wdata = '0;
			end
			S_FREE_WR: begin
				if (!fl_rdata[FL_AVAIL]) begin
					fl_we              = 1'b1;
					fl_waddr           = p_q[AW-1:0];
					fl_wdata[FL_AVAIL] = 1'b1;
					upd.free_inc       = 1'b1;
					upd.dma_inc        = fl_rdata[FL_DMA];
				end
			end
			S_DONE:  done = 1'b1;
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue && (state_d == state_q);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Working registers of the current word.
	always_ff @(posedge clk) begin
		p_s1 <= p_q;
		if (issue) begin
			p_q <= p_q + 1'b1;
		end
		case (state_q)
			S_IDLE: begin
				if (go) begin
					req_q    <= req;
					p_q      <= (req.cmd == CMD_ALLOC) ? SW'(1) : SW'(req.page_index);
					run_q    <= '0;
					prev_q   <= '0;
					first_q  <= '0;
					if (req.cmd == CMD_ALLOC && req.request_size == '0) begin
						status_q <= STAT_BADSIZE;
					end else if (req.cmd == CMD_ALLOC &&
					             (SW'(req.request_size) > free_total ||
					              !(req.dest_kind == KIND_REG || req.dest_kind == KIND_KERN ||
					                req.dest_kind == KIND_DMA))) begin
						status_q <= STAT_NOFIT;
					end else begin
						status_q <= STAT_DONE;
					end
				end
			end
			S_CSCAN: begin
				if (vld_s1) begin
					if (!in_range) begin
						status_q <= STAT_NOFIT;
					end else if (fits) begin
						run_q <= run_q + 1'b1;
						if (run_q + 1'b1 == size_w) begin
							end_q   <= p_s1;
							p_q     <= p_s1 + 1'b1 - size_w;
							first_q <= p_s1 + 1'b1 - size_w;
						end
					end else begin
						run_q <= '0;
					end
				end
			end
			S_RSCAN: begin
				if (vld_s1) begin
					if (!in_range) begin
						status_q <= STAT_NOFIT;
					end else if (fl_rdata[FL_AVAIL]) begin
						run_q <= run_q + 1'b1;
						if (run_q + 1'b1 == size_w) begin
							end_q <= p_s1;
							p_q   <= SW'(1);
						end
					end
				end
			end
			S_RTAKE: begin
				if (vld_s1 && fl_rdata[FL_AVAIL]) begin
					prev_q <= p_s1;
					if (prev_q == '0) begin
						first_q <= p_s1;
					end
				end
			end
			S_FREE_WR: begin
				if (!fl_rdata[FL_AVAIL] && !link_end) begin
					p_q <= nxt_w;
				end
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign status     = status_q;
	assign grant_page = (status_q == STAT_DONE) ? first_q[PAGE_W-1:0] : '0;

`ifndef SYNTHESIS
	// A contiguous grant never writes past the end of its run.
	a_ctake_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CTAKE && fl_we) |-> (p_s1 <= end_q))
		else $error("contiguous grant wrote beyond its run");

	// The result strobe is followed by the idle state.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == S_IDLE))
		else $error("sequencer not idle after result");

	// An accepted word always makes the block busy.
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy)
		else $error("accepted word did not start the sequencer");

	// Only a load both removes from and adds to the free count in the same cycle.
	a_upd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD_WR) |-> !(upd.free_inc && upd.free_dec))
		else $error("free count raised and lowered together");
`endif

endmodule
